FILE: hw/rtl/epoch_deferred_free_queue_assert.svh
// ------------------------------------------------------------------------
// epoch deferred free queue assertion macros
// clocked on clk, disabled while rst_n is low
// ------------------------------------------------------------------------
`ifndef EPOCH_DEFERRED_FREE_QUEUE_ASSERT_SVH
`define EPOCH_DEFERRED_FREE_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define EDFQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define EDFQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define EDFQ_ASSERT(label, prop, msg)

`define EDFQ_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

FILE: hw/rtl/edfq_pkg.sv
// ------------------------------------------------------------------------
// edfq_pkg
// shared constants, opcodes and interface types of the deferred free queue
// ------------------------------------------------------------------------
package edfq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int READER_SLOTS  = 8;
    localparam int EPOCH_BITS    = 32;

    localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_IDX_BITS = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;

    localparam int ADDR_BITS     = 48;
    localparam int OP_BITS       = 3;
    localparam int SLOT_BITS     = 3;
    localparam int THR_BITS      = 7;
    localparam int TICK_BITS     = 32;
    localparam int COUNT_BITS    = 7;

    localparam int S_TDATA_BITS  = 56;
    localparam int M_TDATA_BITS  = 56;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL  = CFG_INDEX_BITS'(1);

    localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(16);
    localparam logic [EPOCH_BITS-1:0] EPOCH_RESET = EPOCH_BITS'(1);

    typedef enum logic [OP_BITS-1:0] {
        OP_RETIRE  = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_TICK    = 3'd2,
        OP_READER  = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_RECLAIM = 3'd5
    } op_t;

    typedef struct packed {
        logic                 start;
        logic                 set_en;
        logic [SLOT_BITS-1:0] set_slot;
        logic                 set_active;
    } slot_req_t;

    typedef struct packed {
        logic                  done;
        logic                  positive;
        logic [EPOCH_BITS-1:0] bound;
    } min_res_t;

endpackage

FILE: hw/rtl/edfq_slots.sv
// ------------------------------------------------------------------------
// edfq_slots
// reader slot table and a one-slot-per-cycle minimum epoch scanner
// ------------------------------------------------------------------------
module edfq_slots (
    input  logic                            clk,
    input  logic                            rst_n,
    input  edfq_pkg::slot_req_t             req,
    input  logic [edfq_pkg::EPOCH_BITS-1:0] global_epoch,
    output edfq_pkg::min_res_t              res
);
    import edfq_pkg::*;

    localparam logic [SLOT_IDX_BITS-1:0] LAST_IDX = SLOT_IDX_BITS'(READER_SLOTS - 1);

    logic [READER_SLOTS-1:0]  active_reg, active_next;
    logic [EPOCH_BITS-1:0]    slot_epoch_reg [READER_SLOTS];
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     any_reg, any_next;
    logic [SLOT_IDX_BITS-1:0] idx_reg, idx_next;
    logic [EPOCH_BITS-1:0]    low_reg, low_next;
    logic [SLOT_IDX_BITS-1:0] set_idx;
    logic                     set_hit;
    logic                     cur_active;
    logic [EPOCH_BITS-1:0]    cur_epoch;
    logic                     take;

    always_comb
    begin
        set_idx    = SLOT_IDX_BITS'(req.set_slot);
        set_hit    = req.set_en && (int'(req.set_slot) < READER_SLOTS);
        cur_active = active_reg[idx_reg];
        cur_epoch  = slot_epoch_reg[idx_reg];
        take       = cur_active && (!any_reg || (cur_epoch < low_reg));

        active_next = active_reg;
        if (set_hit)
        begin
            active_next[set_idx] = req.set_active;
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        any_next  = any_reg;
        idx_next  = idx_reg;
        low_next  = low_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            any_next  = 1'b0;
            idx_next  = '0;
            low_next  = global_epoch;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                low_next = cur_epoch;
                any_next = 1'b1;
            end
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            any_reg    <= 1'b0;
            idx_reg    <= '0;
            low_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            any_reg    <= any_next;
            idx_reg    <= idx_next;
            low_reg    <= low_next;
        end
    end

    // slot epochs only matter behind an active bit
    always_ff @(posedge clk)
    begin
        if (set_hit && req.set_active)
        begin
            slot_epoch_reg[set_idx] <= global_epoch;
        end
    end

    assign res.done     = done_reg;
    assign res.positive = (low_reg >= EPOCH_BITS'(2));
    assign res.bound    = low_reg - EPOCH_BITS'(1);

endmodule

FILE: hw/rtl/epoch_deferred_free_queue.sv
// ------------------------------------------------------------------------
// epoch_deferred_free_queue
// deferred free fifo of retired addresses stamped with the global epoch,
// released once every active reader has moved past their epoch, or on clear
//
// channel  dir  signals                        word
// s        in   s_tvalid s_tready              tuser op, tdata addr/slot/active
// m        out  m_tvalid m_tready              tuser freed_valid, tlast, tdata
// cfg      in   cfg_valid cfg_ready            cfg_index, cfg_data
//
// one item at a time; a word with no release is held until m_tready
// reclaim: gate, slot scan, then a read and compare per queue entry checked
//   against the bound, and a read, load and response per released entry
// clear: a read, load and response per entry through the one address read port
// reset is asynchronous and needs no clearing pass; cfg_ready is always high
// ------------------------------------------------------------------------
`include "epoch_deferred_free_queue_assert.svh"

module epoch_deferred_free_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [edfq_pkg::S_TDATA_BITS-1:0]   s_tdata,   // addr, reader_slot, reader_active
    input  logic [edfq_pkg::OP_BITS-1:0]        s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [edfq_pkg::M_TDATA_BITS-1:0]   m_tdata,   // freed_addr, pending_count, overflow
    output logic                                m_tuser,   // freed_valid
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [edfq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [edfq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import edfq_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_GATE     = 8'b0000_0010,
        ST_MIN      = 8'b0000_0100,
        ST_SCAN_RD  = 8'b0000_1000,
        ST_SCAN_CMP = 8'b0001_0000,
        ST_EMIT_RD  = 8'b0010_0000,
        ST_EMIT_LD  = 8'b0100_0000,
        ST_RESP     = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic                  ovf_reg, ovf_next;
    logic [THR_BITS-1:0]   thr_reg;
    logic [TICK_BITS-1:0]  intv_reg;
    logic [IDX_BITS-1:0]   head_reg, head_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [TICK_BITS-1:0]  tick_reg, tick_next;
    logic [TICK_BITS-1:0]  last_tick_reg, last_tick_next;
    logic [CNT_BITS-1:0]   npop_reg, npop_next;
    logic [IDX_BITS-1:0]   ptr_reg, ptr_next;
    logic [EPOCH_BITS-1:0] bound_reg, bound_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]  out_addr_reg, out_addr_next;
    logic                  out_fvalid_reg, out_fvalid_next;
    logic                  out_last_reg, out_last_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [ADDR_BITS-1:0]  addr_mem [QUEUE_DEPTH];
    logic [EPOCH_BITS-1:0] epoch_mem [QUEUE_DEPTH];
    logic [ADDR_BITS-1:0]  addr_rdata_reg;
    logic [EPOCH_BITS-1:0] epoch_rdata_reg;

    op_t                   in_op;
    logic [ADDR_BITS-1:0]  in_addr;
    logic [SLOT_BITS-1:0]  in_slot;
    logic                  in_active;

    logic [IDX_BITS:0]     tail_sum;
    logic [IDX_BITS-1:0]   tail;
    logic [IDX_BITS-1:0]   head_inc;
    logic [IDX_BITS-1:0]   ptr_inc;
    logic [CNT_BITS-1:0]   count_inc;
    logic [TICK_BITS-1:0]  tick_diff;
    logic                  gated;
    logic                  mem_we;
    logic                  load_empty;
    logic                  scan_done;
    logic                  emit_last;

    slot_req_t             slot_req;
    min_res_t              min_res;

    assign in_op     = op_t'(s_tuser);
    assign in_addr   = s_tdata[ADDR_BITS-1:0];
    assign in_slot   = s_tdata[ADDR_BITS +: SLOT_BITS];
    assign in_active = s_tdata[ADDR_BITS + SLOT_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ovf_reg, out_count_reg, out_addr_reg};
    assign m_tuser  = out_fvalid_reg;
    assign m_tlast  = out_last_reg;

    assign tail_sum  = (IDX_BITS+1)'(head_reg) + (IDX_BITS+1)'(count_reg);
    assign tail      = (tail_sum >= (IDX_BITS+1)'(QUEUE_DEPTH))
                     ? IDX_BITS'(tail_sum - (IDX_BITS+1)'(QUEUE_DEPTH))
                     : IDX_BITS'(tail_sum);
    assign head_inc  = (head_reg == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ptr_inc   = (ptr_reg == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign tick_diff = tick_reg - last_tick_reg;
    assign gated     = (intv_reg != '0) && (tick_diff < intv_reg);
    assign emit_last = (npop_reg == CNT_BITS'(1));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ovf_next        = ovf_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        epoch_next      = epoch_reg;
        tick_next       = tick_reg;
        last_tick_next  = last_tick_reg;
        npop_next       = npop_reg;
        ptr_next        = ptr_reg;
        bound_next      = bound_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_fvalid_next = out_fvalid_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        out_ovf_next    = out_ovf_reg;
        mem_we          = 1'b0;
        load_empty      = 1'b0;
        scan_done       = 1'b0;

        slot_req.start      = 1'b0;
        slot_req.set_en     = 1'b0;
        slot_req.set_slot   = in_slot;
        slot_req.set_active = in_active;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = in_op;
                    ovf_next = 1'b0;
                    case (in_op)
                        OP_RETIRE:
                        begin
                            if (count_reg == CNT_BITS'(QUEUE_DEPTH))
                            begin
                                ovf_next   = 1'b1;
                                load_empty = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_inc;
                                if (COUNT_BITS'(count_inc) >= thr_reg)
                                begin
                                    state_next = ST_GATE;
                                end
                                else
                                begin
                                    load_empty = 1'b1;
                                end
                            end
                        end
                        OP_ADVANCE:
                        begin
                            epoch_next = epoch_reg + 1'b1;
                            load_empty = 1'b1;
                        end
                        OP_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            load_empty = 1'b1;
                        end
                        OP_READER:
                        begin
                            slot_req.set_en = 1'b1;
                            load_empty      = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                head_next  = '0;
                                load_empty = 1'b1;
                            end
                            else
                            begin
                                npop_next  = count_reg;
                                count_next = '0;
                                state_next = ST_EMIT_RD;
                            end
                        end
                        OP_RECLAIM:
                        begin
                            state_next = ST_GATE;
                        end
                        default:
                        begin
                            load_empty = 1'b1;
                        end
                    endcase
                end
            end
            ST_GATE:
            begin
                if (gated)
                begin
                    load_empty = 1'b1;
                end
                else
                begin
                    if (intv_reg != '0)
                    begin
                        last_tick_next = tick_reg;
                    end
                    slot_req.start = 1'b1;
                    state_next     = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (min_res.done)
                begin
                    bound_next = min_res.bound;
                    if (!min_res.positive)
                    begin
                        load_empty = 1'b1;
                    end
                    else
                    begin
                        ptr_next   = head_reg;
                        npop_next  = '0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                // epoch memory output is registered from ptr_reg, used in the next cycle
                if (npop_reg == count_reg)
                begin
                    scan_done = 1'b1;
                end
                else
                begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (epoch_rdata_reg <= bound_reg)
                begin
                    npop_next  = npop_reg + 1'b1;
                    ptr_next   = ptr_inc;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    scan_done = 1'b1;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_valid_next  = 1'b1;
                out_addr_next   = addr_rdata_reg;
                out_fvalid_next = 1'b1;
                out_last_next   = emit_last;
                out_count_next  = COUNT_BITS'(count_reg);
                out_ovf_next    = 1'b0;
                npop_next       = npop_reg - 1'b1;
                head_next       = (emit_last && (op_reg == OP_CLEAR)) ? '0 : head_inc;
                state_next      = ST_RESP;
            end
            ST_RESP:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = (npop_reg == '0) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (scan_done)
        begin
            if (npop_reg == '0)
            begin
                load_empty = 1'b1;
            end
            else
            begin
                count_next = count_reg - npop_reg;
                state_next = ST_EMIT_RD;
            end
        end

        // single word with nothing released
        if (load_empty)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = '0;
            out_fvalid_next = 1'b0;
            out_last_next   = 1'b1;
            out_count_next  = COUNT_BITS'(count_next);
            out_ovf_next    = ovf_next;
            npop_next       = '0;
            state_next      = ST_RESP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_RETIRE;
            ovf_reg       <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            epoch_reg     <= EPOCH_RESET;
            tick_reg      <= '0;
            last_tick_reg <= '0;
            npop_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ovf_reg       <= ovf_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            epoch_reg     <= epoch_next;
            tick_reg      <= tick_next;
            last_tick_reg <= last_tick_next;
            npop_reg      <= npop_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg      <= bound_next;
        out_addr_reg   <= out_addr_next;
        out_fvalid_reg <= out_fvalid_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
        out_ovf_reg    <= out_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            intv_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg  <= cfg_data[THR_BITS-1:0];
                CFG_INTERVAL:  intv_reg <= cfg_data[TICK_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // queue storage, one write and one read port each
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            addr_mem[tail]  <= in_addr;
            epoch_mem[tail] <= epoch_reg;
        end
        epoch_rdata_reg <= epoch_mem[ptr_reg];
        addr_rdata_reg  <= addr_mem[head_reg];
    end

    edfq_slots u_slots (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (slot_req),
        .global_epoch (epoch_reg),
        .res          (min_res)
    );

    `EDFQ_ASSERT(a_count_range, count_reg <= CNT_BITS'(QUEUE_DEPTH), "queue count above depth")
    `EDFQ_ASSERT(a_idle_out_empty, (state_reg == ST_IDLE) |-> !out_valid_reg, "word held in idle")
    `EDFQ_ASSERT(a_empty_is_last, (out_valid_reg && !out_fvalid_reg) |-> out_last_reg, "empty word not last")
    `EDFQ_ASSERT(a_scan_in_queue, (state_reg == ST_SCAN_CMP) |-> (npop_reg < count_reg), "scan past tail")
    `EDFQ_ASSERT(a_emit_has_pop, (state_reg == ST_EMIT_LD) |-> (npop_reg != '0), "release with none left")
    `EDFQ_ASSERT_NEXT(a_resp_to_idle, (state_reg == ST_RESP) && m_tready && (npop_reg == '0), state_reg == ST_IDLE, "final word did not return to idle")

endmodule
